// File: sv/pts_pkg.sv
package pts_pkg;

    localparam int MaxRows = 64;
    localparam int RowW    = $clog2(MaxRows);
    localparam int QW      = 32;
    localparam int DivSteps = 48;
    localparam int DivCntW  = $clog2(DivSteps + 1);

    localparam logic signed [QW-1:0] QMax = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] QMin = 32'sh8000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SUB,
        ST_DIV_U,
        ST_DIV_R,
        ST_STORE,
        ST_BS_READ,
        ST_BS_MUL,
        ST_BS_CALC,
        ST_BS_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mul_start;
        logic sub;
        logic div_u_start;
        logic div_r_start;
        logic store;
        logic bs_init;
        logic bs_read;
        logic bs_mul;
        logic bs_calc;
        logic out_load;
        logic out_take;
        logic end_run;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic is_last;
        logic bs_at_zero;
        logic out_busy;
    } t_status;

    function automatic logic signed [QW-1:0] sat64(input logic signed [64:0] v);
        logic signed [QW-1:0] r;
        if (v > 65'(QMax)) r = QMax;
        else if (v < 65'(QMin)) r = QMin;
        else r = v[QW-1:0];
        return r;
    endfunction

    // product rounded to nearest, ties away from zero, saturated
    function automatic logic signed [QW-1:0] qround(input logic signed [63:0] p);
        logic [63:0] m;
        logic [63:0] q;
        logic signed [64:0] r;
        m = p[63] ? 64'(-p) : 64'(p);
        q = (m + 64'd32768) >> 16;
        r = p[63] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return sat64(r);
    endfunction

endpackage

// File: sv/projected_tridiagonal_solver.sv
// channel  | direction | handshake                | payload
// s_axis   | in        | s_axis_tvalid/tready     | tdata 5 x q16.16, tlast = last row
// m_axis   | out       | m_axis_tvalid/tready     | tdata value+index, tuser singular, tlast
// cfg      | in        | i_cfg_we                 | i_cfg_wdata = projected mode
// sequence per row: products and pivot, then the two 48-step divisions on the shared
// serial divider, then store and return to idle; back substitution reads, multiplies,
// computes and outputs one result at a time
// reset: synchronous, active low; clears row count, singular flag and mode
// stalls: a held result stalls back substitution only; input is taken only in idle
module projected_tridiagonal_solver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // coef_lower, coef_diag, coef_upper, rhs_value, floor_value
    input  logic [159:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // row_index [5:0], solution_value [37:6], zero fill to 40
    output logic [39:0]  m_axis_tdata,
    // singular
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata
);
    pts_pkg::t_cmd    cmd;
    pts_pkg::t_status status;
    logic             r_mode;
    logic             in_fire;
    logic [pts_pkg::RowW-1:0]      out_idx;
    logic signed [pts_pkg::QW-1:0] out_val;

    assign in_fire = s_axis_tvalid & s_axis_tready;

    // mode register, sampled when back substitution starts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= 1'b0;
        else if (i_cfg_we) r_mode <= i_cfg_wdata;
    end

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pts_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_row_data     (s_axis_tdata),
        .i_row_last     (s_axis_tlast),
        .i_mode         (r_mode),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_index    (out_idx),
        .o_out_value    (out_val),
        .o_out_singular (m_axis_tuser),
        .o_out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, out_val, out_idx};
endmodule

// File: sv/pts_divider.sv
module pts_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [pts_pkg::QW-1:0]   i_num,
    input  logic signed [pts_pkg::QW-1:0]   i_den,
    output logic                            o_done,
    output logic signed [pts_pkg::QW-1:0]   o_quot
);
    // restoring divide of (|num| << 16 + |den|/2) by |den|, one bit per cycle
    logic [47:0]                     r_dividend;
    logic [32:0]                     r_rem;
    logic [47:0]                     r_quot;
    logic [31:0]                     r_den;
    logic                            r_neg;
    logic                            r_busy;
    logic                            r_done;
    logic [pts_pkg::DivCntW-1:0]     r_cnt;
    logic [32:0]                     n_trial;
    logic [33:0]                     n_shift;
    logic [31:0]                     n_nmag;
    logic [31:0]                     n_dmag;
    logic [48:0]                     n_sum;
    logic signed [64:0]              n_res;

    always_comb begin
        n_nmag  = i_num[31] ? 32'(-i_num) : 32'(i_num);
        n_dmag  = i_den[31] ? 32'(-i_den) : 32'(i_den);
        n_sum   = {1'b0, n_nmag, 16'd0} + 49'({1'b0, n_dmag[31:1]});
        n_shift = {r_rem, r_dividend[47]};
        n_trial = 33'(n_shift - {2'b0, r_den});
        n_res   = r_neg ? -$signed({17'd0, r_quot}) : $signed({17'd0, r_quot});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pts_pkg::DivCntW'(pts_pkg::DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // sum fits 48 bits: 2^47 + 2^31 < 2^48
            r_dividend <= n_sum[47:0];
            r_den      <= n_dmag;
            r_rem      <= '0;
            r_quot     <= '0;
            r_neg      <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_dividend <= {r_dividend[46:0], 1'b0};
            if (n_shift >= {2'b0, r_den}) begin
                r_rem  <= n_trial;
                r_quot <= {r_quot[46:0], 1'b1};
            end else begin
                r_rem  <= n_shift[32:0];
                r_quot <= {r_quot[46:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = pts_pkg::sat64(n_res);
endmodule

// File: sv/pts_datapath.sv
module pts_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pts_pkg::t_cmd                   i_cmd,
    output pts_pkg::t_status                o_status,
    input  logic [159:0]                    i_row_data,
    input  logic                            i_row_last,
    input  logic                            i_mode,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [pts_pkg::RowW-1:0]        o_out_index,
    output logic signed [pts_pkg::QW-1:0]   o_out_value,
    output logic                            o_out_singular,
    output logic                            o_out_last
);
    localparam int RW = pts_pkg::RowW;

    logic signed [31:0] r_lo, r_dg, r_up, r_rh, r_fl;
    logic               r_last;
    logic               r_close;
    logic [RW:0]        r_row;
    logic [RW-1:0]      r_bs;
    logic               r_sing, r_mode;
    logic signed [31:0] r_prev_u, r_prev_r;
    logic signed [63:0] r_p1, r_p2;
    logic signed [31:0] r_piv, r_num, r_uq;
    logic signed [31:0] r_y;
    logic signed [31:0] r_su, r_sr, r_sf;
    logic               r_ov;
    logic [RW-1:0]      r_oi;
    logic signed [31:0] r_oy;
    logic               r_os, r_ol;

    logic signed [31:0] mem_u [pts_pkg::MaxRows];
    logic signed [31:0] mem_r [pts_pkg::MaxRows];
    logic signed [31:0] mem_f [pts_pkg::MaxRows];

    logic               div_start, div_done;
    logic signed [31:0] div_num, div_den, div_q;
    logic signed [31:0] n_piv, n_num, n_y, n_yp;
    logic [RW-1:0]      n_idx;

    assign n_idx = r_row[RW-1:0];
    assign div_start = i_cmd.div_u_start | i_cmd.div_r_start;
    assign div_num = i_cmd.div_u_start ? r_up : r_num;
    assign div_den = r_piv;

    pts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        n_piv = pts_pkg::sat64(65'(r_dg) - 65'(pts_pkg::qround(r_p1)));
        n_num = pts_pkg::sat64(65'(r_rh) - 65'(pts_pkg::qround(r_p2)));
        n_y   = pts_pkg::sat64(65'(r_sr) - 65'(pts_pkg::qround(r_p1)));
        n_yp  = (r_mode && n_y < r_sf) ? r_sf : n_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_sing <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cmd.store) begin
                if (r_piv == 32'sd0) r_sing <= 1'b1;
                if (!(r_last || n_idx == RW'(pts_pkg::MaxRows - 1)))
                    r_row <= r_row + 1'b1;
            end
            if (i_cmd.end_run) begin
                r_row  <= '0;
                r_sing <= 1'b0;
            end
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            {r_fl, r_rh, r_up, r_dg, r_lo} <= i_row_data;
            r_last <= i_row_last;
        end
        if (i_cmd.mul_start) begin
            r_p1 <= r_lo * r_prev_u;
            r_p2 <= r_lo * r_prev_r;
        end
        if (i_cmd.sub) begin
            if (r_row == '0) begin
                r_piv <= r_dg;
                r_num <= r_rh;
            end else begin
                r_piv <= n_piv;
                r_num <= n_num;
            end
        end
        if (div_done && !i_cmd.store) r_uq <= div_q;
        if (i_cmd.store) begin
            logic signed [31:0] u_v, r_v;
            u_v = (r_piv == 32'sd0) ? 32'sd0 : r_uq;
            r_v = (r_piv == 32'sd0) ? 32'sd0 : div_q;
            mem_u[n_idx] <= u_v;
            mem_r[n_idx] <= r_v;
            mem_f[n_idx] <= r_fl;
            r_prev_u <= u_v;
            r_prev_r <= r_v;
            // closing decision taken on the index of the row just stored
            r_close  <= r_last || n_idx == RW'(pts_pkg::MaxRows - 1);
        end
        if (i_cmd.bs_init) begin
            r_bs   <= n_idx;
            r_mode <= i_mode;
        end
        if (i_cmd.bs_read) begin
            r_su <= mem_u[r_bs];
            r_sr <= mem_r[r_bs];
            r_sf <= mem_f[r_bs];
        end
        if (i_cmd.bs_mul) r_p1 <= r_su * r_y;
        if (i_cmd.bs_calc) begin
            if (r_bs == n_idx) r_y <= (r_mode && r_sr < r_sf) ? r_sf : r_sr;
            else r_y <= n_yp;
        end
        if (i_cmd.out_load) begin
            r_oi <= r_bs;
            r_oy <= r_y;
            r_os <= r_sing;
            r_ol <= (r_bs == '0);
        end
        if (i_cmd.out_take) r_bs <= r_bs - 1'b1;
    end

    assign o_status.div_done   = div_done;
    assign o_status.is_last    = r_close;
    assign o_status.bs_at_zero = (r_bs == '0);
    assign o_status.out_busy   = r_ov && !i_out_ready;

    assign o_out_valid    = r_ov;
    assign o_out_index    = r_oi;
    assign o_out_value    = r_oy;
    assign o_out_singular = r_os;
    assign o_out_last     = r_ol;
endmodule

// File: sv/pts_ctrl.sv
module pts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    output logic              o_in_ready,
    input  pts_pkg::t_status  i_status,
    output pts_pkg::t_cmd     o_cmd
);
    pts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= pts_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pts_pkg::ST_IDLE:    if (i_in_fire) n_state = pts_pkg::ST_LOAD;
            pts_pkg::ST_LOAD:    n_state = pts_pkg::ST_MUL;
            pts_pkg::ST_MUL:     n_state = pts_pkg::ST_SUB;
            pts_pkg::ST_SUB:     n_state = pts_pkg::ST_DIV_U;
            pts_pkg::ST_DIV_U:   if (i_status.div_done) n_state = pts_pkg::ST_DIV_R;
            pts_pkg::ST_DIV_R:   if (i_status.div_done) n_state = pts_pkg::ST_STORE;
            pts_pkg::ST_STORE:   n_state = pts_pkg::ST_IDLE;
            pts_pkg::ST_BS_READ: n_state = pts_pkg::ST_BS_MUL;
            pts_pkg::ST_BS_MUL:  n_state = pts_pkg::ST_BS_CALC;
            pts_pkg::ST_BS_CALC: n_state = pts_pkg::ST_BS_OUT;
            pts_pkg::ST_BS_OUT:  if (!i_status.out_busy)
                n_state = i_status.bs_at_zero ? pts_pkg::ST_IDLE : pts_pkg::ST_BS_READ;
            default:             n_state = pts_pkg::ST_IDLE;
        endcase
        if (r_state == pts_pkg::ST_DIV_R && i_status.div_done)
            n_state = pts_pkg::ST_STORE;
        if (r_state == pts_pkg::ST_STORE && i_status.is_last)
            n_state = pts_pkg::ST_BS_READ;
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pts_pkg::ST_IDLE:    begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_fire;
            end
            pts_pkg::ST_LOAD:    o_cmd.mul_start = 1'b1;
            pts_pkg::ST_MUL:     o_cmd.sub = 1'b1;
            pts_pkg::ST_SUB:     o_cmd.div_u_start = 1'b1;
            pts_pkg::ST_DIV_U:   o_cmd.div_r_start = i_status.div_done;
            pts_pkg::ST_DIV_R:   o_cmd.store = i_status.div_done;
            pts_pkg::ST_STORE:   o_cmd.bs_init = i_status.is_last;
            pts_pkg::ST_BS_READ: o_cmd.bs_read = 1'b1;
            pts_pkg::ST_BS_MUL:  o_cmd.bs_mul = 1'b1;
            pts_pkg::ST_BS_CALC: o_cmd.bs_calc = 1'b1;
            pts_pkg::ST_BS_OUT:  if (!i_status.out_busy) begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_take = !i_status.bs_at_zero;
                o_cmd.end_run  = i_status.bs_at_zero;
            end
            default:             o_cmd = '0;
        endcase
    end
endmodule

// File: sv/pts_checker.sv
module pts_assertions (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic         m_axis_tlast
);
    // a pending result stays offered until it is taken
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] == 6'd0)
        else $error("last result not row 0");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
endmodule

bind projected_tridiagonal_solver pts_assertions u_pts_assertions (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
